// File: src/digit_sum_range_count_and_first_assert.svh
// Assertion macros for the digit-sum range counter checker.
// No dependencies; included by the checker file only.
`ifndef DIGIT_SUM_RANGE_COUNT_AND_FIRST_ASSERT_SVH
`define DIGIT_SUM_RANGE_COUNT_AND_FIRST_ASSERT_SVH

// same-cycle implication
`define DSRC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("dsrc assertion failed");

// next-cycle implication
`define DSRC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("dsrc assertion failed");

`endif

// File: src/dsrc_pkg.sv
// Shared types, constants and state encodings for the digit-sum range counter.
// No dependencies; imported by every module of the block.
package dsrc_pkg;

	localparam int DIGITS_DEF    = 18;
	localparam int SUM_SLOTS_DEF = 256;
	localparam int VAL_W         = 60;
	localparam int CNT_W         = 61;
	localparam int TBL_W         = 60;
	localparam int SUM_W         = 8;
	localparam int ROW_FW        = 5;
	localparam int COL_FW        = 8;
	localparam int POW_IW        = 5;
	localparam int WIN_LEN       = 10;
	localparam int ADDR_W        = 3;
	localparam int DATA_W        = 32;

	localparam logic REG_IDX_TARGET = 1'b0;

	localparam logic [63:0] POW10_TAB [20] = '{
		64'd1,
		64'd10,
		64'd100,
		64'd1000,
		64'd10000,
		64'd100000,
		64'd1000000,
		64'd10000000,
		64'd100000000,
		64'd1000000000,
		64'd10000000000,
		64'd100000000000,
		64'd1000000000000,
		64'd10000000000000,
		64'd100000000000000,
		64'd1000000000000000,
		64'd10000000000000000,
		64'd100000000000000000,
		64'd1000000000000000000,
		64'd10000000000000000000
	};

	typedef struct packed {
		logic [VAL_W-1:0] range_low;
		logic [VAL_W-1:0] range_high;
	} query_t;

	typedef struct packed {
		logic [VAL_W-1:0] match_count;
		logic [VAL_W-1:0] first_match_res;
		logic             match_found;
	} result_t;

	typedef struct packed {
		logic [ROW_FW-1:0] row;
		logic [COL_FW-1:0] col;
	} tbl_rd_t;

	typedef struct packed {
		logic             go;
		logic [VAL_W-1:0] x;
	} walk_req_t;

	typedef struct packed {
		logic             done;
		logic [CNT_W-1:0] count;
	} walk_rsp_t;

	typedef enum logic [1:0] {
		BL_IDLE,
		BL_INIT,
		BL_ROW,
		BL_DRAIN
	} bld_state_t;

	typedef enum logic [1:0] {
		WK_IDLE,
		WK_RUN,
		WK_DONE
	} walk_state_t;

	typedef enum logic [3:0] {
		C_IDLE,
		C_BUILD,
		C_BASE,
		C_BASE_W,
		C_HIGH,
		C_HIGH_W,
		C_SRCH,
		C_SRCH_W,
		C_DONE
	} ctrl_state_t;

endpackage

// File: src/dsrc_table.sv
// Count table memory (length x digit sum) and its rebuild sequencer.
// Depends on dsrc_pkg. Two registered read ports, one write port.
module dsrc_table #(
	parameter int DIGITS    = dsrc_pkg::DIGITS_DEF,
	parameter int SUM_SLOTS = dsrc_pkg::SUM_SLOTS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     build_go,
	output logic                     build_done,
	input  dsrc_pkg::tbl_rd_t        walk_rd,
	output logic [dsrc_pkg::TBL_W-1:0] rd_data
);
	import dsrc_pkg::*;

	localparam int RW    = $clog2(DIGITS + 1);
	localparam int SW    = $clog2(SUM_SLOTS);
	localparam int AW    = RW + SW;
	localparam int DEPTH = (DIGITS + 1) * (2 ** SW);

	logic [TBL_W-1:0] mem [DEPTH];

	bld_state_t       state_q, state_d;
	logic [RW-1:0]    row_q;
	logic [SW-1:0]    col_q;
	logic             v_s1, sub_s1, first_s1;
	logic [RW-1:0]    row_s1;
	logic [SW-1:0]    col_s1;
	logic [TBL_W-1:0] win_q, win_d, rd_a_q, rd_b_q, wd;
	logic [AW-1:0]    wa, ra_a, ra_b;
	logic             we, col_last, row_last;

	assign col_last = col_q == SW'(SUM_SLOTS - 1);
	assign row_last = row_q == RW'(DIGITS);

	always_comb begin
		state_d = state_q;
		case (state_q)
			BL_IDLE: begin
				if (build_go) state_d = BL_INIT;
			end
			BL_INIT: begin
				if (col_last) state_d = BL_ROW;
			end
			BL_ROW: begin
				if (col_last && row_last) state_d = BL_DRAIN;
			end
			BL_DRAIN: begin
				state_d = BL_IDLE;
			end
			default: begin
				state_d = BL_IDLE;
			end
		endcase
	end

	// sliding window over ten entries of the previous row
	assign win_d = (first_s1 ? '0 : win_q) + rd_a_q - (sub_s1 ? rd_b_q : '0);

	always_comb begin
		build_done = state_q == BL_DRAIN;
		ra_b       = {row_q - RW'(1), col_q - SW'(WIN_LEN)};
		if (state_q == BL_ROW) begin
			ra_a = {row_q - RW'(1), col_q};
		end else begin
			ra_a = {walk_rd.row[RW-1:0], walk_rd.col[SW-1:0]};
		end
		if (state_q == BL_INIT) begin
			we = 1'b1;
			wa = {row_q, col_q};
			wd = (col_q == '0) ? TBL_W'(1) : '0;
		end else begin
			we = v_s1;
			wa = {row_s1, col_s1};
			wd = win_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BL_IDLE;
			row_q   <= '0;
			col_q   <= '0;
			v_s1    <= 1'b0;
		end else begin
			state_q <= state_d;
			v_s1    <= state_q == BL_ROW;
			case (state_q)
				BL_IDLE: begin
					row_q <= '0;
					col_q <= '0;
				end
				BL_INIT: begin
					col_q <= col_last ? '0 : col_q + SW'(1);
					if (col_last) row_q <= RW'(1);
				end
				BL_ROW: begin
					col_q <= col_last ? '0 : col_q + SW'(1);
					if (col_last && !row_last) row_q <= row_q + RW'(1);
				end
				default: begin
					col_q <= '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		row_s1   <= row_q;
		col_s1   <= col_q;
		sub_s1   <= col_q >= SW'(WIN_LEN);
		first_s1 <= col_q == '0;
		if (v_s1) win_q <= win_d;
	end

	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		rd_a_q <= mem[ra_a];
		rd_b_q <= mem[ra_b];
	end

	assign rd_data = rd_a_q;

endmodule

// File: src/dsrc_walk.sv
// Digit walk: counts 0..x with the target digit sum using the count table.
// Depends on dsrc_pkg; reads the table through one read port of dsrc_table.
module dsrc_walk #(
	parameter int DIGITS    = dsrc_pkg::DIGITS_DEF,
	parameter int SUM_SLOTS = dsrc_pkg::SUM_SLOTS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [dsrc_pkg::SUM_W-1:0] target,
	input  dsrc_pkg::walk_req_t        req,
	output dsrc_pkg::walk_rsp_t        rsp,
	output dsrc_pkg::tbl_rd_t          tbl_rd,
	input  logic [dsrc_pkg::TBL_W-1:0] tbl_data
);
	import dsrc_pkg::*;

	localparam int RW = $clog2(DIGITS + 1);

	walk_state_t      state_q, state_d;
	logic [VAL_W-1:0] rem_q;
	logic [RW-1:0]    pos_q;
	logic [SUM_W-1:0] used_q;
	logic [CNT_W-1:0] total_q;
	logic             add_s1;
	logic [63:0]      pw;
	logic             take, hit, t_ok, pos_zero;

	// one unit of the current digit per cycle; digit exhausted when rem < 10^pos
	assign pw       = POW10_TAB[POW_IW'(pos_q)];
	assign take     = 64'(rem_q) >= pw;
	assign hit      = used_q <= target;
	assign t_ok     = {1'b0, target} < (SUM_W + 1)'(SUM_SLOTS);
	assign pos_zero = pos_q == '0;

	always_comb begin
		state_d = state_q;
		case (state_q)
			WK_IDLE: begin
				if (req.go) state_d = WK_RUN;
			end
			WK_RUN: begin
				if (!take && pos_zero) state_d = WK_DONE;
			end
			WK_DONE: begin
				state_d = WK_IDLE;
			end
			default: begin
				state_d = WK_IDLE;
			end
		endcase
	end

	always_comb begin
		rsp.done   = state_q == WK_DONE;
		rsp.count  = t_ok ? total_q + CNT_W'(used_q == target) : '0;
		tbl_rd.row = ROW_FW'(pos_q);
		tbl_rd.col = COL_FW'(target - used_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= WK_IDLE;
			add_s1  <= 1'b0;
		end else begin
			state_q <= state_d;
			add_s1  <= (state_q == WK_RUN) && take && hit;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == WK_IDLE && req.go) begin
			rem_q   <= req.x;
			pos_q   <= RW'(DIGITS - 1);
			used_q  <= '0;
			total_q <= '0;
		end else begin
			if (add_s1) total_q <= total_q + CNT_W'(tbl_data);
			if (state_q == WK_RUN) begin
				if (take) begin
					rem_q  <= rem_q - pw[VAL_W-1:0];
					used_q <= used_q + SUM_W'(1);
				end else if (!pos_zero) begin
					pos_q <= pos_q - RW'(1);
				end
			end
		end
	end

endmodule

// File: src/digit_sum_range_count_and_first.sv
// Top level of the digit-sum range counter: control sequencer and register port.
// Depends on dsrc_pkg, dsrc_table and dsrc_walk.
//
// Usage: write target_digit_sum over the APB port (byte address 0) while the
// block is idle. Present a query word (range_low, range_high) with start; it
// is taken when start is high and busy is low. busy stays high until the result
// word is shown: done is high for exactly one cycle with result valid, and
// result holds that word until the next query is taken.
// Per query: a rebuild of the count table, then up to two counting walks (of
// range_low - 1 and of range_high, after clamping) and about 60 search walks
// that bisect the range for the first match; each digit walk takes one step
// per cycle, and the table rebuild and the digit walks set the query time.
// One query is in flight at a time; start is ignored while busy.
// Reset clears the sequencers and the target register; the count table holds
// no valid contents until a query rebuilds it.
module digit_sum_range_count_and_first #(
	parameter int DIGITS    = dsrc_pkg::DIGITS_DEF,
	parameter int SUM_SLOTS = dsrc_pkg::SUM_SLOTS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  dsrc_pkg::query_t            query,
	output logic                        done,
	output dsrc_pkg::result_t           result,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [dsrc_pkg::ADDR_W-1:0] paddr,
	input  logic [dsrc_pkg::DATA_W-1:0] pwdata,
	output logic [dsrc_pkg::DATA_W-1:0] prdata,
	output logic                        pready
);
	import dsrc_pkg::*;

	localparam logic [63:0] LIM = POW10_TAB[DIGITS] - 64'd1;

	ctrl_state_t      state_q, state_d;
	logic [SUM_W-1:0] target_q;
	logic [VAL_W-1:0] high_in_q, lo_q, hi_q, sl_q, sh_q, mid_q, mid_d;
	logic [VAL_W-1:0] lo_in, hi_in;
	logic [CNT_W-1:0] base_q, count_q;
	logic             ord_ok_q, srch_more, build_go, build_done;
	walk_req_t        wreq;
	walk_rsp_t        wrsp;
	tbl_rd_t          tbl_rd;
	logic [TBL_W-1:0] tbl_data;

	dsrc_table #(
		.DIGITS   (DIGITS),
		.SUM_SLOTS(SUM_SLOTS)
	) u_table (
		.clk       (clk),
		.arst_n    (arst_n),
		.build_go  (build_go),
		.build_done(build_done),
		.walk_rd   (tbl_rd),
		.rd_data   (tbl_data)
	);

	dsrc_walk #(
		.DIGITS   (DIGITS),
		.SUM_SLOTS(SUM_SLOTS)
	) u_walk (
		.clk     (clk),
		.arst_n  (arst_n),
		.target  (target_q),
		.req     (wreq),
		.rsp     (wrsp),
		.tbl_rd  (tbl_rd),
		.tbl_data(tbl_data)
	);

	// config register
	assign pready = 1'b1;
	assign prdata = (paddr[ADDR_W-1] == REG_IDX_TARGET) ? DATA_W'(target_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
		end else if (psel && penable && pwrite && pready
			&& paddr[ADDR_W-1] == REG_IDX_TARGET) begin
			target_q <= pwdata[SUM_W-1:0];
		end
	end

	// bounds clamp to the largest DIGITS-digit value
	assign lo_in = (64'(query.range_low) > LIM) ? LIM[VAL_W-1:0] : query.range_low;
	assign hi_in = (64'(query.range_high) > LIM) ? LIM[VAL_W-1:0] : query.range_high;

	assign mid_d     = sl_q + ((sh_q - sl_q) >> 1);
	assign srch_more = (count_q != '0) && (sl_q < sh_q);

	always_comb begin
		state_d = state_q;
		case (state_q)
			C_IDLE: begin
				if (start) state_d = C_BUILD;
			end
			C_BUILD: begin
				if (build_done) state_d = ord_ok_q ? C_BASE : C_DONE;
			end
			C_BASE: begin
				state_d = (lo_q == '0) ? C_HIGH : C_BASE_W;
			end
			C_BASE_W: begin
				if (wrsp.done) state_d = C_HIGH;
			end
			C_HIGH: begin
				state_d = C_HIGH_W;
			end
			C_HIGH_W: begin
				if (wrsp.done) state_d = C_SRCH;
			end
			C_SRCH: begin
				state_d = srch_more ? C_SRCH_W : C_DONE;
			end
			C_SRCH_W: begin
				if (wrsp.done) state_d = C_SRCH;
			end
			C_DONE: begin
				state_d = C_IDLE;
			end
			default: begin
				state_d = C_IDLE;
			end
		endcase
	end

	always_comb begin
		busy     = state_q != C_IDLE;
		done     = state_q == C_DONE;
		build_go = (state_q == C_IDLE) && start;
		wreq.go  = 1'b0;
		wreq.x   = mid_d;
		case (state_q)
			C_BASE: begin
				wreq.go = lo_q != '0;
				wreq.x  = lo_q - VAL_W'(1);
			end
			C_HIGH: begin
				wreq.go = 1'b1;
				wreq.x  = hi_q;
			end
			C_SRCH: begin
				wreq.go = srch_more;
			end
			default: begin
				wreq.go = 1'b0;
			end
		endcase
		result.match_count     = count_q[VAL_W-1:0];
		result.match_found     = count_q != '0;
		result.first_match_res = (count_q != '0) ? sl_q : high_in_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			C_IDLE: begin
				if (start) begin
					high_in_q <= query.range_high;
					lo_q      <= lo_in;
					hi_q      <= hi_in;
					sl_q      <= lo_in;
					sh_q      <= hi_in;
					ord_ok_q  <= query.range_low <= query.range_high;
					base_q    <= '0;
					count_q   <= '0;
				end
			end
			C_BASE_W: begin
				if (wrsp.done) base_q <= wrsp.count;
			end
			C_HIGH_W: begin
				if (wrsp.done) count_q <= wrsp.count - base_q;
			end
			C_SRCH: begin
				mid_q <= mid_d;
			end
			C_SRCH_W: begin
				if (wrsp.done) begin
					if (wrsp.count != base_q) begin
						sh_q <= mid_q;
					end else begin
						sl_q <= mid_q + VAL_W'(1);
					end
				end
			end
			default: begin
				mid_q <= mid_q;
			end
		endcase
	end

endmodule

// File: src/dsrc_checker.sv
// Port-level checker for the digit-sum range counter, bound to the top level.
// Depends on dsrc_pkg and digit_sum_range_count_and_first_assert.svh.
`include "digit_sum_range_count_and_first_assert.svh"

module dsrc_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input dsrc_pkg::result_t result
);
	import dsrc_pkg::*;

	`DSRC_ASSERT_IMP(a_done_while_busy, clk, arst_n, done, busy)
	`DSRC_ASSERT_NXT(a_accept_sets_busy, clk, arst_n, start && !busy, busy)
	`DSRC_ASSERT_NXT(a_done_single, clk, arst_n, done, !done)
	`DSRC_ASSERT_IMP(a_found_nonzero, clk, arst_n, done && result.match_found, result.match_count != '0)
	`DSRC_ASSERT_IMP(a_none_zero, clk, arst_n, done && !result.match_found, result.match_count == '0)

endmodule

bind digit_sum_range_count_and_first dsrc_checker u_dsrc_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.done  (done),
	.result(result)
);
